// ===== rtl/hvtf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hvtf_pkg
// Types, pattern tables and helpers shared by the visible-text filter.
// ----------------------------------------------------------------------------
package hvtf_pkg;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t in_byte;
    logic  doc_end;
  } in_item_t;

  typedef struct packed {
    byte_t text_byte;
    logic  byte_valid;
    logic  end_of_text;
  } out_item_t;

  typedef enum logic [3:0] {
    MODE_TEXT   = 4'b0001,
    MODE_OPENER = 4'b0010,
    MODE_TAG    = 4'b0100,
    MODE_SKIP   = 4'b1000
  } scan_mode_e;

  typedef enum logic [1:0] {
    KIND_COMMENT  = 2'd0,
    KIND_SCRIPT   = 2'd1,
    KIND_STYLE    = 2'd2,
    KIND_NOSCRIPT = 2'd3
  } kind_e;

  localparam int unsigned NumKinds = 4;
  localparam int unsigned OpenDepth = 9;
  localparam int unsigned CloseDepth = 11;

  typedef logic [$clog2(OpenDepth)-1:0] open_idx_t;
  typedef logic [$clog2(CloseDepth)-1:0] close_idx_t;
  typedef logic [3:0] progress_t;

  typedef struct packed {
    scan_mode_e mode;
    progress_t  opener_progress;
    kind_e      opener_kind;
    progress_t  closer_progress;
  } scan_state_t;

  localparam scan_state_t ScanReset = '{
    mode:            MODE_TEXT,
    opener_progress: 4'd0,
    opener_kind:     KIND_COMMENT,
    closer_progress: 4'd0
  };

  localparam byte_t CharLt   = 8'h3c;
  localparam byte_t CharGt   = 8'h3e;
  localparam byte_t CharDash = 8'h2d;

  localparam byte_t OPEN_PAT [NumKinds][OpenDepth] = '{
    '{"<", "!", "-", "-", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"<", "s", "c", "r", "i", "p", "t", 8'h00, 8'h00},
    '{"<", "s", "t", "y", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"<", "n", "o", "s", "c", "r", "i", "p", "t"}
  };

  localparam progress_t OPEN_LEN [NumKinds] = '{4'd4, 4'd7, 4'd6, 4'd9};

  localparam byte_t CLOSE_PAT [NumKinds][CloseDepth] = '{
    '{"-", "-", ">", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"<", "/", "s", "c", "r", "i", "p", "t", ">", 8'h00, 8'h00},
    '{"<", "/", "s", "t", "y", "l", "e", ">", 8'h00, 8'h00, 8'h00},
    '{"<", "/", "n", "o", "s", "c", "r", "i", "p", "t", ">"}
  };

  localparam progress_t CLOSE_LEN [NumKinds] = '{4'd3, 4'd9, 4'd8, 4'd11};

  function automatic byte_t to_lower(byte_t c);
    byte_t r;
    r = c;
    if (c >= "A" && c <= "Z") begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  // openers share the leading '<'; script and style also share the 's'
  function automatic logic prefix_ok(kind_e k, kind_e cur, progress_t p);
    logic ok;
    ok = (k == cur) || (p <= 4'd1);
    if (p == 4'd2 && ((k == KIND_SCRIPT && cur == KIND_STYLE) ||
                      (k == KIND_STYLE && cur == KIND_SCRIPT))) begin
      ok = 1'b1;
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hvtf_closer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hvtf_closer
// Next-state function of the closing-string matcher with partial-match restart.
// ----------------------------------------------------------------------------
module hvtf_closer (
  input  var hvtf_pkg::kind_e     kind_i,
  input  var hvtf_pkg::progress_t progress_i,
  input  var hvtf_pkg::byte_t     char_i,
  output var hvtf_pkg::progress_t progress_o,
  output var logic                done_o
);
  import hvtf_pkg::*;

  close_idx_t idx;
  logic       hit;
  logic       restart;
  logic       dash_hold;

  always_comb begin
    idx       = close_idx_t'(progress_i);
    hit       = 1'b0;
    if (progress_i < CLOSE_LEN[kind_i]) begin
      hit = (char_i == CLOSE_PAT[kind_i][idx]);
    end
    restart   = (char_i == CLOSE_PAT[kind_i][0]);
    // a run of dashes keeps "--" matched in a comment
    dash_hold = (kind_i == KIND_COMMENT) && (progress_i == 4'd2) && (char_i == CharDash);
    if (hit) begin
      progress_o = progress_i + 4'd1;
    end else if (dash_hold) begin
      progress_o = 4'd2;
    end else if (restart) begin
      progress_o = 4'd1;
    end else begin
      progress_o = 4'd0;
    end
    done_o = (progress_o == CLOSE_LEN[kind_i]);
  end

endmodule
`default_nettype wire

// ===== rtl/hvtf_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hvtf_scan
// Per-byte scanner step: markup state update and the kept-byte result.
// ----------------------------------------------------------------------------
module hvtf_scan (
  input  var hvtf_pkg::scan_state_t state_i,
  input  var hvtf_pkg::in_item_t    item_i,
  output var hvtf_pkg::scan_state_t state_o,
  output var logic                  has_result_o,
  output var hvtf_pkg::out_item_t   result_o
);
  import hvtf_pkg::*;

  byte_t       lc;
  logic        keep;
  logic        found;
  kind_e       new_kind;
  progress_t   next_p;
  open_idx_t   p_idx;
  progress_t   close_next;
  logic        close_done;
  scan_state_t st;

  hvtf_closer u_closer (
    .kind_i     (state_i.opener_kind),
    .progress_i (state_i.closer_progress),
    .char_i     (lc),
    .progress_o (close_next),
    .done_o     (close_done)
  );

  always_comb begin
    lc       = to_lower(item_i.in_byte);
    p_idx    = open_idx_t'(state_i.opener_progress);
    found    = 1'b0;
    new_kind = KIND_COMMENT;
    for (int k = NumKinds - 1; k >= 0; k--) begin
      if (state_i.opener_progress < OPEN_LEN[k] &&
          prefix_ok(kind_e'(k[1:0]), state_i.opener_kind, state_i.opener_progress) &&
          OPEN_PAT[k][p_idx] == lc) begin
        found    = 1'b1;
        new_kind = kind_e'(k[1:0]);
      end
    end
    next_p = state_i.opener_progress + 4'd1;
  end

  always_comb begin
    st   = state_i;
    keep = 1'b0;
    case (state_i.mode)
      MODE_OPENER: begin
        if (found) begin
          st.opener_kind     = new_kind;
          st.opener_progress = next_p;
          if (next_p == OPEN_LEN[new_kind]) begin
            st.mode            = MODE_SKIP;
            st.opener_progress = 4'd0;
            st.closer_progress = 4'd0;
          end
        end else begin
          st.opener_progress = 4'd0;
          st.opener_kind     = KIND_COMMENT;
          st.mode            = (item_i.in_byte == CharGt) ? MODE_TEXT : MODE_TAG;
        end
      end
      MODE_TAG: begin
        if (item_i.in_byte == CharGt) begin
          st.mode = MODE_TEXT;
        end
      end
      MODE_SKIP: begin
        st.closer_progress = close_next;
        if (close_done) begin
          st.mode            = MODE_TEXT;
          st.closer_progress = 4'd0;
          st.opener_kind     = KIND_COMMENT;
        end
      end
      default: begin
        if (item_i.in_byte == CharLt) begin
          st.mode            = MODE_OPENER;
          st.opener_progress = 4'd1;
          st.opener_kind     = KIND_COMMENT;
        end else begin
          st.mode = MODE_TEXT;
          keep    = 1'b1;
        end
      end
    endcase

    if (item_i.doc_end) begin
      st = ScanReset;
    end

    state_o              = st;
    has_result_o         = keep | item_i.doc_end;
    result_o.text_byte   = keep ? item_i.in_byte : 8'h00;
    result_o.byte_valid  = keep;
    result_o.end_of_text = item_i.doc_end;
  end

endmodule
`default_nettype wire

// ===== rtl/html_visible_text_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// html_visible_text_filter
// Passes only the visible text bytes of an HTML byte stream.
// ----------------------------------------------------------------------------
// Takes one document byte per cycle and sustains one byte per cycle with no
// bubbles while out_stall_i does not hold back a result; a byte passes from the
// input register to the result register. The rate is set by the combinational
// scanner step between the two registers, which updates the markup state for
// every byte. Bytes inside markup give no result; the last byte of a document
// always gives one, flagged end_of_text, and returns the scanner to plain text.
module html_visible_text_filter (
  input  var logic                clk_i,
  input  var logic                rst_ni,
  input  var logic                in_valid_i,
  output var logic                in_stall_o,
  input  var hvtf_pkg::in_item_t  in_item_i,
  output var logic                out_valid_o,
  input  var logic                out_stall_i,
  output var hvtf_pkg::out_item_t out_item_o
);
  import hvtf_pkg::*;

  logic        in_valid_q;
  in_item_t    in_item_q;
  scan_state_t state_q;
  scan_state_t state_d;
  logic        out_valid_q;
  out_item_t   out_item_q;
  logic        has_result;
  out_item_t   result;
  logic        advance;
  logic        in_xfer;

  hvtf_scan u_scan (
    .state_i      (state_q),
    .item_i       (in_item_q),
    .state_o      (state_d),
    .has_result_o (has_result),
    .result_o     (result)
  );

  assign advance    = in_valid_q && (!has_result || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ScanReset;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance && has_result) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q <= in_item_i;
    end
    if (advance && has_result) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

// ===== tb/html_visible_text_filter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_visible_text_filter_checker
// Watches both channels of the visible-text filter, keeps its own copy of the
// markup scanner state, predicts the result of every byte transfer and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module html_visible_text_filter_checker
  import hvtf_pkg::*;
(
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        in_valid_i,
  input  var logic        in_stall_i,
  input  var in_item_t    in_item_i,
  input  var logic        out_valid_i,
  input  var logic        out_stall_i,
  input  var out_item_t   out_item_i,
  output int unsigned     mismatch_count_o,
  output int unsigned     pending_o
);

  localparam byte_t LtChar = 8'h3c;
  localparam byte_t GtChar = 8'h3e;
  localparam int unsigned ReportLimit = 10;

  scan_mode_e  mode;
  int          open_prog;
  kind_e       kind;
  int          close_prog;
  out_item_t   visible_text_q[$];
  int unsigned mismatches = 0;

  function automatic byte_t fold_case(byte_t c);
    return (c >= "A" && c <= "Z") ? byte_t'(c + 8'd32) : c;
  endfunction

  function automatic string opener_text(kind_e k);
    case (k)
      KIND_COMMENT: return "<!--";
      KIND_SCRIPT:  return "<script";
      KIND_STYLE:   return "<style";
      default:      return "<noscript";
    endcase
  endfunction

  function automatic string closer_text(kind_e k);
    case (k)
      KIND_COMMENT: return "-->";
      KIND_SCRIPT:  return "</script>";
      KIND_STYLE:   return "</style>";
      default:      return "</noscript>";
    endcase
  endfunction

  // longest closer prefix that ends the matched part followed by c
  function automatic int closer_step(string pat, int done, byte_t c);
    int  len;
    int  k;
    int  i;
    bit  ok;
    len = pat.len();
    k = (done + 1 > len) ? len : done + 1;
    if (done >= len) begin
      done = 0;
    end
    while (k >= 1) begin
      if (pat[k-1] == c && k - 1 <= done) begin
        ok = 1'b1;
        for (i = 0; i < k - 1; i++) begin
          if (pat[i] != pat[done-(k-1)+i]) begin
            ok = 1'b0;
          end
        end
        if (ok) begin
          return k;
        end
      end
      k--;
    end
    return 0;
  endfunction

  function automatic void clear_scan();
    mode = MODE_TEXT;
    open_prog = 0;
    kind = KIND_COMMENT;
    close_prog = 0;
  endfunction

  task automatic predict_visible(input in_item_t it);
    byte_t     lc;
    bit        keep;
    bit        found;
    bit        same;
    int        k;
    int        i;
    kind_e     cand;
    string     pat;
    string     cur;
    out_item_t res;
    lc = fold_case(it.in_byte);
    keep = 1'b0;
    case (mode)
      MODE_OPENER: begin
        found = 1'b0;
        cur = opener_text(kind);
        for (k = 0; k < NumKinds && !found; k++) begin
          cand = kind_e'(k);
          pat = opener_text(cand);
          same = 1'b1;
          for (i = 0; i < open_prog; i++) begin
            if (i >= pat.len() || i >= cur.len() || pat[i] != cur[i]) begin
              same = 1'b0;
            end
          end
          if (pat.len() > open_prog && same && pat[open_prog] == lc) begin
            kind = cand;
            found = 1'b1;
          end
        end
        if (found) begin
          open_prog++;
          pat = opener_text(kind);
          if (open_prog == pat.len()) begin
            mode = MODE_SKIP;
            open_prog = 0;
            close_prog = 0;
          end
        end else begin
          open_prog = 0;
          kind = KIND_COMMENT;
          mode = (it.in_byte == GtChar) ? MODE_TEXT : MODE_TAG;
        end
      end
      MODE_TAG: begin
        if (it.in_byte == GtChar) begin
          mode = MODE_TEXT;
        end
      end
      MODE_SKIP: begin
        pat = closer_text(kind);
        close_prog = closer_step(pat, close_prog, lc);
        if (close_prog >= pat.len()) begin
          mode = MODE_TEXT;
          close_prog = 0;
          kind = KIND_COMMENT;
        end
      end
      default: begin
        if (it.in_byte == LtChar) begin
          mode = MODE_OPENER;
          open_prog = 1;
          kind = KIND_COMMENT;
        end else begin
          mode = MODE_TEXT;
          keep = 1'b1;
        end
      end
    endcase
    if (it.doc_end) begin
      clear_scan();
    end
    if (keep || it.doc_end) begin
      res.text_byte = keep ? it.in_byte : 8'h00;
      res.byte_valid = keep;
      res.end_of_text = it.doc_end;
      visible_text_q.insert(visible_text_q.size(), res);
    end
  endtask

  task automatic note_mismatch(input string what, input out_item_t exp, input out_item_t act);
    mismatches++;
    if (mismatches <= ReportLimit) begin
      $display("%0t: %s: expected byte=%02h valid=%b end=%b, got byte=%02h valid=%b end=%b",
               $realtime, what, exp.text_byte, exp.byte_valid, exp.end_of_text,
               act.text_byte, act.byte_valid, act.end_of_text);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp;
    if (!rst_ni) begin
      clear_scan();
      visible_text_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (visible_text_q.size() == 0) begin
          note_mismatch("unexpected result", '0, out_item_i);
        end else begin
          exp = visible_text_q.pop_front();
          if (exp.text_byte !== out_item_i.text_byte ||
              exp.byte_valid !== out_item_i.byte_valid ||
              exp.end_of_text !== out_item_i.end_of_text) begin
            note_mismatch("result mismatch", exp, out_item_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_visible(in_item_i);
      end
    end
    pending_o <= visible_text_q.size();
    mismatch_count_o <= mismatches;
  end

endmodule

// ===== tb/tb_html_visible_text_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_html_visible_text_filter
// Drives short directed documents and then random HTML-like documents with
// comments, script, style and noscript blocks, plain tags, broken openers,
// partial closers and noise into the filter, with random idle bursts on both
// sides; the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_html_visible_text_filter;
  import hvtf_pkg::*;

  localparam int unsigned ItemTarget = 1150;
  localparam int unsigned CalmTail = 150;
  localparam int unsigned DrainCycles = 20;
  localparam byte_t LtChar = 8'h3c;
  localparam byte_t GtChar = 8'h3e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  bit          send_gaps;
  bit          recv_stalls;
  int unsigned sent;
  int unsigned mismatch_count;
  int unsigned pending;
  byte_t       doc_q[$];

  always #6 clk = ~clk;

  html_visible_text_filter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  html_visible_text_filter_checker text_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_item_i       (out_item),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    #5_000_000;
    $display("tb_html_visible_text_filter: FAIL");
    $finish;
  end

  // receiver stall bursts
  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!recv_stalls) begin
        hold = 0;
        out_stall <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_byte(input byte_t b, input logic last);
    int gap;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{in_byte: b, doc_end: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_doc();
    int i;
    for (i = 0; i < doc_q.size(); i++) begin
      send_byte(doc_q[i], i == doc_q.size() - 1);
    end
  endtask

  task automatic add_byte(input byte_t b);
    doc_q.insert(doc_q.size(), b);
  endtask

  function automatic byte_t shuffle_case(byte_t c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) begin
      return byte_t'(c - 8'd32);
    end
    return c;
  endfunction

  function automatic string open_tag(kind_e k);
    case (k)
      KIND_COMMENT: return "<!--";
      KIND_SCRIPT:  return "<script";
      KIND_STYLE:   return "<style";
      default:      return "<noscript";
    endcase
  endfunction

  function automatic string close_tag(kind_e k);
    case (k)
      KIND_COMMENT: return "-->";
      KIND_SCRIPT:  return "</script>";
      KIND_STYLE:   return "</style>";
      default:      return "</noscript>";
    endcase
  endfunction

  task automatic push_str(input string s, input bit mix);
    int i;
    for (i = 0; i < s.len(); i++) begin
      add_byte(mix ? shuffle_case(s[i]) : byte_t'(s[i]));
    end
  endtask

  task automatic push_letters(input int n);
    repeat (n) add_byte(shuffle_case(byte_t'("a" + $urandom_range(0, 25))));
  endtask

  task automatic push_text(input int n);
    byte_t c;
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        c = byte_t'($urandom_range(0, 255));
      end else begin
        c = byte_t'($urandom_range(32, 126));
      end
      add_byte(c == LtChar ? byte_t'(" ") : c);
    end
  endtask

  task automatic push_noise(input int n);
    repeat (n) add_byte(byte_t'($urandom_range(0, 255)));
  endtask

  task automatic push_element(input bit closed);
    kind_e k;
    string c;
    int    n;
    k = kind_e'($urandom_range(0, 3));
    c = close_tag(k);
    push_str(open_tag(k), 1'b1);
    if ($urandom_range(0, 3) == 0) begin
      push_letters($urandom_range(1, 3));
    end
    if ($urandom_range(0, 2) == 0) begin
      push_str(" a=\"b\">", 1'b0);
    end
    n = $urandom_range(0, 4);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: push_text($urandom_range(1, 5));
        1: push_str(c.substr(0, $urandom_range(0, c.len() - 2)), 1'b1);
        2: push_noise($urandom_range(1, 3));
        default: begin
          push_str(c.substr(0, 0), 1'b0);
          push_str(c.substr(0, $urandom_range(0, c.len() - 2)), 1'b1);
        end
      endcase
    end
    if (closed) begin
      push_str(c, 1'b1);
    end
  endtask

  task automatic push_tag();
    add_byte(LtChar);
    if ($urandom_range(0, 2) == 0) begin
      add_byte("/");
    end
    push_letters($urandom_range(1, 6));
    if ($urandom_range(0, 2) == 0) begin
      push_str(" x='1' <y", 1'b0);
    end
    add_byte(GtChar);
  endtask

  task automatic push_broken();
    string o;
    o = open_tag(kind_e'($urandom_range(0, 3)));
    push_str(o.substr(0, $urandom_range(1, o.len() - 2)), 1'b1);
    if ($urandom_range(0, 1) == 0) begin
      add_byte(GtChar);
    end else begin
      push_text($urandom_range(1, 3));
      add_byte(GtChar);
    end
  endtask

  task automatic build_doc();
    int target;
    doc_q.delete();
    target = $urandom_range(1, 40);
    while (doc_q.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: push_text($urandom_range(1, 6));
        3, 4:    push_tag();
        5, 6, 7: push_element(1'b1);
        8:       push_broken();
        default: push_noise($urandom_range(1, 4));
      endcase
    end
    case ($urandom_range(0, 7))
      0: push_element(1'b0);
      1: begin
        add_byte(LtChar);
        push_letters($urandom_range(0, 3));
      end
      default: ;
    endcase
  endtask

  task automatic send_fixed_doc(input string s);
    doc_q.delete();
    push_str(s, 1'b0);
    send_doc();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    // comment opener overlaps its closer, broken opener ending on '>'
    send_fixed_doc("<!-->a-->b");
    send_fixed_doc("<s>c<<x>d");
    // opener followed by more name letters, left unclosed
    send_fixed_doc("<scripts");

    while (sent < ItemTarget) begin
      if (sent + CalmTail >= ItemTarget) begin
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
      end else begin
        send_gaps = $urandom_range(0, 3) != 0;
        recv_stalls = $urandom_range(0, 3) != 0;
      end
      build_doc();
      send_doc();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_html_visible_text_filter: PASS");
    end else begin
      $display("tb_html_visible_text_filter: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hvtf_pkg.sv
rtl/hvtf_closer.sv
rtl/hvtf_scan.sv
rtl/html_visible_text_filter.sv
tb/html_visible_text_filter_checker.sv
tb/tb_html_visible_text_filter.sv
